>>> hw/rtl/sbp_pkg.sv
// Package for the sample bit packer: payload structs and shared constants.
// Used by sbp_calc and sample_bit_packer_row_flush_core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sbp_pkg;

  localparam int unsigned SampleBitsW      = 6;
  localparam int unsigned MaxSampleBitsDef = 32;
  localparam int unsigned PendBitsW        = 7;
  localparam int unsigned PendCntW         = 3;
  localparam int unsigned ByteW            = 8;

  localparam logic [SampleBitsW-1:0] SampleBitsRst = 6'd8;

  typedef struct packed {
    logic [31:0] sample_value;
    logic        row_end;
  } in_t;

  typedef struct packed {
    logic [ByteW-1:0] packed_byte;
    logic             last_of_run;
  } out_t;

endpackage

`default_nettype wire

>>> hw/rtl/sbp_calc.sv
// Combinational packing step: turns one sample plus the pending bits into a byte group.
// Depends on sbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbp_calc
  import sbp_pkg::*;
#(
  parameter int unsigned MaxSampleBits = MaxSampleBitsDef,
  localparam int unsigned AccW     = MaxSampleBits + PendBitsW,
  localparam int unsigned MaxBytes = (AccW + ByteW - 1) / ByteW,
  localparam int unsigned CntW     = $clog2(MaxBytes + 1)
) (
  input  logic [SampleBitsW-1:0]          sample_bits_i,
  input  logic [PendBitsW-1:0]            pend_bits_i,
  input  logic [PendCntW-1:0]             pend_cnt_i,
  input  in_t                             item_i,
  output logic [MaxBytes-1:0][ByteW-1:0]  bytes_o,
  output logic [CntW-1:0]                 cnt_o,
  output logic [PendBitsW-1:0]            pend_bits_o,
  output logic [PendCntW-1:0]             pend_cnt_o
);

  localparam int unsigned StreamW = MaxBytes * ByteW;
  localparam int unsigned BitCntW = $clog2(AccW + 1);
  localparam int unsigned ShW     = $clog2(StreamW + 1);
  localparam logic [SampleBitsW-1:0] WidthMax = SampleBitsW'(MaxSampleBits);

  logic [SampleBitsW-1:0] width;
  logic [32:0]            mask;
  logic [31:0]            sample;
  logic [StreamW-1:0]     sample_x;
  logic [AccW-1:0]        acc;
  logic [BitCntW-1:0]     bit_cnt;
  logic [ShW-1:0]         shamt;
  logic [StreamW-1:0]     stream;
  logic [2:0]             rem;
  logic                   flush;
  logic [7:0]             rem_mask;

  always_comb begin
    width    = (sample_bits_i > WidthMax) ? WidthMax : sample_bits_i;
    mask     = (33'(1) << width) - 33'(1);
    sample   = item_i.sample_value & mask[31:0];
    sample_x = StreamW'(sample);

    // Pending bits sit above the new sample; the stream is left aligned so that
    // byte k is always at the same fixed position.
    acc      = (AccW'(pend_bits_i) << width) | AccW'(sample);
    bit_cnt  = BitCntW'(pend_cnt_i) + BitCntW'(width);
    shamt    = ShW'(StreamW) - ShW'(bit_cnt);
    stream   = StreamW'(acc) << shamt;
    rem      = bit_cnt[2:0];
    flush    = item_i.row_end && (rem != 3'd0);
    rem_mask = (8'(1) << rem) - 8'(1);

    if (width[2:0] == 3'd0) begin
      // Byte-aligned copy, least significant byte first; pending bits dropped.
      for (int k = 0; k < MaxBytes; k++) begin
        bytes_o[k] = sample_x[ByteW*k +: ByteW];
      end
      cnt_o       = CntW'(width >> 3);
      pend_bits_o = '0;
      pend_cnt_o  = '0;
    end else begin
      for (int k = 0; k < MaxBytes; k++) begin
        bytes_o[k] = stream[StreamW-1-ByteW*k -: ByteW];
      end
      cnt_o       = CntW'(bit_cnt >> 3) + CntW'(flush);
      pend_bits_o = flush ? '0 : (acc[PendBitsW-1:0] & rem_mask[PendBitsW-1:0]);
      pend_cnt_o  = flush ? '0 : rem;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sample_bit_packer_row_flush_core.sv
// Top level of the MSB-first sample bit packer with row-end flush; byte-aligned widths go least significant byte first.
// Depends on sbp_pkg and sbp_calc.
//
//   Channel  | Direction | Handshake                     | Transaction
//   ---------+-----------+-------------------------------+------------------------------
//   cfg      | in        | cfg_we_i                      | sample_bits write (6 bits)
//   in       | in        | in_valid_i / in_stall_o       | one sample plus row-end mark
//   out      | out       | out_valid_o / out_stall_i     | one packed byte plus last mark
//
// An input transaction is packed in the cycle it is accepted, and its byte group is
// registered. A group is then sent out one byte per cycle while out_stall_i is low, since
// there is a single output byte port; a group holds up to five bytes, for a packed width
// just below the maximum that meets pending bits and ends a row.
// Reset clears the pending bits, all valid flags, and sets sample_bits to 8; no sweep.
// A stalled output holds its byte; the staging register lets the next sample be taken
// while the current group is still draining.
`timescale 1ns / 1ps
`default_nettype none

module sample_bit_packer_row_flush_core
  import sbp_pkg::*;
#(
  parameter int unsigned MaxSampleBits = MaxSampleBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [SampleBitsW-1:0] cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  in_t                    in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_t                   out_data_o
);

  localparam int unsigned AccW     = MaxSampleBits + PendBitsW;
  localparam int unsigned MaxBytes = (AccW + ByteW - 1) / ByteW;
  localparam int unsigned CntW     = $clog2(MaxBytes + 1);
  localparam int unsigned IdxW     = $clog2(MaxBytes);

  // Configuration and packing state.
  logic [SampleBitsW-1:0] sample_bits_q;
  logic [PendBitsW-1:0]   pend_bits_q, pend_bits_d;
  logic [PendCntW-1:0]    pend_cnt_q, pend_cnt_d;

  // Byte group from the packing step.
  logic [MaxBytes-1:0][ByteW-1:0] calc_bytes;
  logic [CntW-1:0]                calc_cnt;

  // Staging register: one finished group waiting for the output stage.
  logic                           stg_valid_q, stg_valid_d;
  logic [MaxBytes-1:0][ByteW-1:0] stg_bytes_q;
  logic [CntW-1:0]                stg_cnt_q;

  // Output stage: the group being sent and the index of the byte on the port.
  logic                           emit_valid_q, emit_valid_d;
  logic [MaxBytes-1:0][ByteW-1:0] emit_bytes_q;
  logic [CntW-1:0]                emit_cnt_q;
  logic [IdxW-1:0]                emit_idx_q, emit_idx_d;

  logic in_fire;
  logic out_fire;
  logic emit_last;
  logic emit_done;
  logic emit_free;
  logic stg_move;

  sbp_calc #(
    .MaxSampleBits(MaxSampleBits)
  ) u_calc (
    .sample_bits_i(sample_bits_q),
    .pend_bits_i  (pend_bits_q),
    .pend_cnt_i   (pend_cnt_q),
    .item_i       (in_data_i),
    .bytes_o      (calc_bytes),
    .cnt_o        (calc_cnt),
    .pend_bits_o  (pend_bits_d),
    .pend_cnt_o   (pend_cnt_d)
  );

  // The current byte is the last of its group when its index plus one equals the count.
  assign emit_last = (CntW'(emit_idx_q) + CntW'(1)) == emit_cnt_q;
  assign out_fire  = emit_valid_q && !out_stall_i;
  assign emit_done = out_fire && emit_last;
  assign emit_free = !emit_valid_q || emit_done;
  assign stg_move  = stg_valid_q && emit_free;

  // The input only waits while the staging register is full and cannot move on.
  assign in_stall_o = stg_valid_q && !emit_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Samples that give no byte only update the pending bits.
  assign stg_valid_d = (stg_valid_q && !stg_move) || (in_fire && (calc_cnt != '0));

  always_comb begin
    emit_valid_d = emit_valid_q;
    emit_idx_d   = emit_idx_q;
    if (stg_move) begin
      emit_valid_d = 1'b1;
      emit_idx_d   = '0;
    end else if (emit_done) begin
      emit_valid_d = 1'b0;
    end else if (out_fire) begin
      emit_idx_d = emit_idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_bits_q <= SampleBitsRst;
      pend_bits_q   <= '0;
      pend_cnt_q    <= '0;
      stg_valid_q   <= 1'b0;
      emit_valid_q  <= 1'b0;
      emit_idx_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        sample_bits_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        pend_bits_q <= pend_bits_d;
        pend_cnt_q  <= pend_cnt_d;
      end
      stg_valid_q  <= stg_valid_d;
      emit_valid_q <= emit_valid_d;
      emit_idx_q   <= emit_idx_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stg_bytes_q <= calc_bytes;
      stg_cnt_q   <= calc_cnt;
    end
    if (stg_move) begin
      emit_bytes_q <= stg_bytes_q;
      emit_cnt_q   <= stg_cnt_q;
    end
  end

  assign out_valid_o            = emit_valid_q;
  assign out_data_o.packed_byte = emit_bytes_q[emit_idx_q];
  assign out_data_o.last_of_run = emit_last;

  // A staged group always holds at least one byte.
  a_stg_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_valid_q |-> (stg_cnt_q != '0))
    else $error("staged byte group is empty");

  // The output index never runs past the group's byte count.
  a_emit_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_valid_q |-> (CntW'(emit_idx_q) < emit_cnt_q))
    else $error("output byte index beyond group count");

  // A row end always leaves no pending bits behind.
  a_row_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.row_end) |=> (pend_cnt_q == '0))
    else $error("pending bits left after row end");

endmodule

`default_nettype wire
